[hw/rtl/oven_cook_timer_controller_macros.svh]
`ifndef OVEN_COOK_TIMER_CONTROLLER_MACROS_SVH
`define OVEN_COOK_TIMER_CONTROLLER_MACROS_SVH

// same-cycle check, clocked by i_clk, off during reset
`define OCT_ASSERT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("oct assertion failed");

// next-cycle check, clocked by i_clk, off during reset
`define OCT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("oct assertion failed");

`endif

[hw/rtl/oct_pkg.sv]
package oct_pkg;

    localparam logic [13:0] SECONDS_MAX = 14'd9999;

    // reciprocal multipliers for divide by 60 and by 10
    localparam logic [14:0] DIV60_MUL   = 15'd17477;
    localparam int          DIV60_SHIFT = 20;
    localparam logic [8:0]  DIV10_MUL   = 9'd410;
    localparam int          DIV10_SHIFT = 12;

    localparam logic       CMD_KEY   = 1'b0;
    localparam logic       CMD_TICK  = 1'b1;
    localparam logic [3:0] KEY_STOP  = 4'd10;
    localparam logic [3:0] KEY_START = 4'd11;

    localparam logic [1:0] CFG_DOOR_CLOSED = 2'd0;
    localparam logic [1:0] CFG_WEIGHT_LIM  = 2'd1;
    localparam logic [1:0] CFG_QUICK_ADD   = 2'd2;

    localparam logic [9:0] DOOR_CLOSED_RST = 10'd1023;
    localparam logic [9:0] WEIGHT_LIM_RST  = 10'd500;
    localparam logic [7:0] QUICK_ADD_RST   = 8'd30;

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_READY,
        MODE_WORKING,
        MODE_SUSP
    } t_mode;

    typedef enum logic [2:0] {
        MSG_NONE,
        MSG_DOOR_OPEN,
        MSG_EMPTY,
        MSG_OVERWEIGHT,
        MSG_HEATING,
        MSG_PAUSE,
        MSG_DONE,
        MSG_CLEARED
    } t_msg;

    typedef struct packed {
        logic       cmd;
        logic [3:0] key_code;
        logic [9:0] door_level;
        logic [9:0] weight_level;
    } t_item;

    typedef struct packed {
        logic [9:0] door_closed_level;
        logic [9:0] weight_limit;
        logic [7:0] quick_add_seconds;
    } t_cfg;

    typedef struct packed {
        logic [4:0] m_tens;
        logic [3:0] m_ones;
        logic [3:0] s_tens;
        logic [3:0] s_ones;
    } t_digits;

    typedef struct packed {
        t_mode      mode;
        logic       heater_on;
        logic       timer_running;
        logic [13:0] secs;
        t_digits    digits;
        t_msg       message;
        logic       beep;
    } t_result;

endpackage

[hw/rtl/oct_time_split.sv]
module oct_time_split (
    input  logic [13:0]      i_secs,
    output oct_pkg::t_digits o_digits
);
    import oct_pkg::*;

    logic [28:0] prod60;
    logic [8:0]  mins;
    logic [13:0] mins_x60;
    logic [5:0]  sec;
    logic [17:0] prod_m;
    logic [4:0]  m_tens;
    logic [8:0]  m_tens_x10;
    logic [14:0] prod_s;
    logic [3:0]  s_tens;
    logic [5:0]  s_tens_x10;

    // minutes and seconds
    assign prod60   = {15'd0, i_secs} * {14'd0, DIV60_MUL};
    assign mins     = prod60[DIV60_SHIFT +: 9];
    assign mins_x60 = {5'd0, mins} * 14'd60;
    assign sec      = 6'(i_secs - mins_x60);

    // tens and ones of each
    assign prod_m     = {9'd0, mins} * {9'd0, DIV10_MUL};
    assign m_tens     = prod_m[DIV10_SHIFT +: 5];
    assign m_tens_x10 = {4'd0, m_tens} * 9'd10;

    assign prod_s     = {9'd0, sec} * {6'd0, DIV10_MUL};
    assign s_tens     = {1'b0, prod_s[DIV10_SHIFT +: 3]};
    assign s_tens_x10 = {2'd0, s_tens} * 6'd10;

    assign o_digits.m_tens = m_tens;
    assign o_digits.m_ones = 4'(mins - m_tens_x10);
    assign o_digits.s_tens = s_tens;
    assign o_digits.s_ones = 4'(sec - s_tens_x10);

endmodule

[hw/rtl/oct_core.sv]
`include "oven_cook_timer_controller_macros.svh"

module oct_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  oct_pkg::t_item   i_item,
    input  oct_pkg::t_cfg    i_cfg,
    output oct_pkg::t_result o_result
);
    import oct_pkg::*;

    t_mode       r_mode, n_mode;
    t_digits     r_digits, n_digits;
    logic [2:0]  r_count, n_count;
    logic [13:0] r_secs, n_secs;
    logic        r_run, n_run;
    logic        r_heat, n_heat;

    t_msg        msg;
    logic        beep;
    logic        start;
    logic        is_digit;
    t_digits     wr_digits;
    t_digits     start_digits;
    t_digits     split_digits;
    logic [14:0] digit_sum;
    logic [13:0] sum_sat;
    logic [14:0] quick_sum;
    logic [13:0] quick_sat;
    logic [13:0] secs_dec;
    logic [13:0] split_in;

    assign is_digit = (i_item.cmd == CMD_KEY) && (i_item.key_code inside {[4'd0:4'd9]});

    // digit written at the entry position
    always_comb begin
        wr_digits = r_digits;
        case (r_count[1:0])
            2'd0: wr_digits.m_tens = {1'b0, i_item.key_code};
            2'd1: wr_digits.m_ones = i_item.key_code;
            2'd2: wr_digits.s_tens = i_item.key_code;
            2'd3: wr_digits.s_ones = i_item.key_code;
            default: wr_digits = r_digits;
        endcase
    end

    assign start_digits = is_digit ? wr_digits : r_digits;
    assign digit_sum = {10'd0, start_digits.m_tens} * 15'd600
                     + {11'd0, start_digits.m_ones} * 15'd60
                     + {11'd0, start_digits.s_tens} * 15'd10
                     + {11'd0, start_digits.s_ones};
    assign sum_sat   = (digit_sum > {1'b0, SECONDS_MAX}) ? SECONDS_MAX : digit_sum[13:0];

    assign quick_sum = {1'b0, r_secs} + {7'd0, i_cfg.quick_add_seconds};
    assign quick_sat = (quick_sum > {1'b0, SECONDS_MAX}) ? SECONDS_MAX : quick_sum[13:0];

    assign secs_dec  = r_secs - 14'd1;
    assign split_in  = (i_item.cmd == CMD_TICK) ? secs_dec : quick_sat;

    oct_time_split u_split (
        .i_secs   (split_in),
        .o_digits (split_digits)
    );

    always_comb begin
        n_mode   = r_mode;
        n_digits = r_digits;
        n_count  = r_count;
        n_secs   = r_secs;
        n_run    = r_run;
        n_heat   = r_heat;
        msg      = MSG_NONE;
        beep     = 1'b0;
        start    = 1'b0;

        if (i_item.cmd == CMD_TICK) begin
            if (r_run) begin
                if (r_secs != 14'd0) begin
                    n_secs   = secs_dec;
                    n_digits = split_digits;
                end else begin
                    n_mode   = MODE_IDLE;
                    n_digits = '0;
                    n_count  = 3'd0;
                    n_secs   = 14'd0;
                    n_run    = 1'b0;
                    n_heat   = 1'b0;
                    msg      = MSG_DONE;
                end
            end
        end else if (is_digit) begin
            beep = 1'b1;
            if (r_count < 3'd4) begin
                n_digits = wr_digits;
                n_count  = r_count + 3'd1;
                start    = (r_count == 3'd3);
            end
        end else if (i_item.key_code == KEY_START) begin
            beep = 1'b1;
            if (r_mode == MODE_SUSP) begin
                n_mode = MODE_WORKING;
                n_run  = 1'b1;
                n_heat = 1'b1;
                msg    = MSG_HEATING;
            end else begin
                start = 1'b1;
            end
        end else if (i_item.key_code == KEY_STOP) begin
            beep = 1'b1;
            if (r_mode == MODE_SUSP) begin
                n_mode   = MODE_IDLE;
                n_digits = '0;
                n_count  = 3'd0;
                n_secs   = 14'd0;
                n_run    = 1'b0;
                n_heat   = 1'b0;
                msg      = MSG_CLEARED;
            end else begin
                n_mode = MODE_SUSP;
                n_run  = 1'b0;
                n_heat = 1'b0;
                msg    = MSG_PAUSE;
            end
        end

        // door and weight checks, then load the time
        if (start) begin
            n_mode = MODE_READY;
            if (i_item.door_level != i_cfg.door_closed_level) begin
                msg = MSG_DOOR_OPEN;
            end else if (i_item.weight_level == 10'd0) begin
                msg = MSG_EMPTY;
            end else if (i_item.weight_level > i_cfg.weight_limit) begin
                msg = MSG_OVERWEIGHT;
            end else begin
                if (r_count == 3'd0) begin
                    n_secs   = quick_sat;
                    n_digits = split_digits;
                end else begin
                    n_secs = sum_sat;
                end
                n_mode = MODE_WORKING;
                n_run  = 1'b1;
                n_heat = 1'b1;
                msg    = MSG_HEATING;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_IDLE;
            r_digits <= '0;
            r_count  <= 3'd0;
            r_secs   <= 14'd0;
            r_run    <= 1'b0;
            r_heat   <= 1'b0;
        end else if (i_fire) begin
            r_mode   <= n_mode;
            r_digits <= n_digits;
            r_count  <= n_count;
            r_secs   <= n_secs;
            r_run    <= n_run;
            r_heat   <= n_heat;
        end
    end

    assign o_result.mode          = n_mode;
    assign o_result.heater_on     = n_heat;
    assign o_result.timer_running = n_run;
    assign o_result.secs          = n_secs;
    assign o_result.digits        = n_digits;
    assign o_result.message       = msg;
    assign o_result.beep          = beep;

    `OCT_ASSERT(a_flags_match, 1'b1, r_heat == r_run)
    `OCT_ASSERT(a_idle_stopped, (r_mode == MODE_IDLE) || (r_mode == MODE_SUSP), !r_run)
    `OCT_ASSERT(a_secs_bounded, 1'b1, (r_secs <= SECONDS_MAX) && (r_count <= 3'd4))
    `OCT_ASSERT_NEXT(a_state_holds, !i_fire, $stable(r_secs) && $stable(r_mode) && $stable(r_count))

endmodule

[hw/rtl/oven_cook_timer_controller.sv]
// channel  direction  handshake                 payload
// in       input      i_in_valid / o_in_stall   cmd, key_code, door_level, weight_level
// out      output     o_out_valid / i_out_stall mode .. beep, one word per input word
// cfg      input      i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// one word per cycle unless i_out_stall holds; input and output words are both registered
// the state update and result are one pass of logic from the input register
// synchronous active-low reset: config to defaults, mode idle, all counts zero
// a stalled result holds in the output register; the input register still fills behind it
module oven_cook_timer_controller (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_cmd,
    input  logic [3:0]  i_key_code,
    input  logic [9:0]  i_door_level,
    input  logic [9:0]  i_weight_level,

    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_mode,
    output logic        o_heater_on,
    output logic        o_timer_running,
    output logic [13:0] o_seconds_left,
    output logic [4:0]  o_minute_tens,
    output logic [3:0]  o_minute_ones,
    output logic [3:0]  o_second_tens,
    output logic [3:0]  o_second_ones,
    output logic [2:0]  o_message,
    output logic        o_beep,

    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [9:0]  i_cfg_data
);
    import oct_pkg::*;

    t_cfg    r_cfg;
    logic    r_in_valid;
    t_item   r_in_item;
    logic    r_out_valid;
    t_result r_out_res;
    t_result core_res;
    logic    out_free;
    logic    fire;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign fire        = r_in_valid && out_free;
    assign o_in_stall  = r_in_valid && !out_free;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.door_closed_level <= DOOR_CLOSED_RST;
            r_cfg.weight_limit      <= WEIGHT_LIM_RST;
            r_cfg.quick_add_seconds <= QUICK_ADD_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_DOOR_CLOSED: r_cfg.door_closed_level <= i_cfg_data;
                CFG_WEIGHT_LIM:  r_cfg.weight_limit      <= i_cfg_data;
                CFG_QUICK_ADD:   r_cfg.quick_add_seconds <= i_cfg_data[7:0];
                default: r_cfg <= r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in_item.cmd          <= i_cmd;
            r_in_item.key_code     <= i_key_code;
            r_in_item.door_level   <= i_door_level;
            r_in_item.weight_level <= i_weight_level;
        end
    end

    oct_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_item   (r_in_item),
        .i_cfg    (r_cfg),
        .o_result (core_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= fire;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_res <= core_res;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_mode          = r_out_res.mode;
    assign o_heater_on     = r_out_res.heater_on;
    assign o_timer_running = r_out_res.timer_running;
    assign o_seconds_left  = r_out_res.secs;
    assign o_minute_tens   = r_out_res.digits.m_tens;
    assign o_minute_ones   = r_out_res.digits.m_ones;
    assign o_second_tens   = r_out_res.digits.s_tens;
    assign o_second_ones   = r_out_res.digits.s_ones;
    assign o_message       = r_out_res.message;
    assign o_beep          = r_out_res.beep;

endmodule

[sim/oct_checker.sv]
module oct_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic        i_cmd,
    input  logic [3:0]  i_key_code,
    input  logic [9:0]  i_door_level,
    input  logic [9:0]  i_weight_level,

    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [1:0]  i_mode,
    input  logic        i_heater_on,
    input  logic        i_timer_running,
    input  logic [13:0] i_seconds_left,
    input  logic [4:0]  i_minute_tens,
    input  logic [3:0]  i_minute_ones,
    input  logic [3:0]  i_second_tens,
    input  logic [3:0]  i_second_ones,
    input  logic [2:0]  i_message,
    input  logic        i_beep,

    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [9:0]  i_cfg_data,

    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import oct_pkg::*;

    localparam logic [3:0] KEY_DIGIT_LAST = 4'd9;

    t_cfg        cfg;
    t_mode       mode_q;
    logic [4:0]  digit_q [4];
    logic [2:0]  entered_q;
    logic [13:0] secs_q;
    logic        timer_q;
    logic        heater_q;
    t_result     status_q [$];
    int          fails = 0;

    assign o_fail_count = fails;

    function automatic void show_secs();
        digit_q[0] = 5'(int'(secs_q) / 600);
        digit_q[1] = 5'((int'(secs_q) % 600) / 60);
        digit_q[2] = 5'((int'(secs_q) % 60) / 10);
        digit_q[3] = 5'(int'(secs_q) % 10);
    endfunction

    function automatic void clear_to_idle();
        mode_q = MODE_IDLE;
        foreach (digit_q[i]) digit_q[i] = '0;
        entered_q = '0;
        secs_q = '0;
        timer_q = 1'b0;
        heater_q = 1'b0;
    endfunction

    function automatic t_msg start_heating();
        mode_q = MODE_WORKING;
        timer_q = 1'b1;
        heater_q = 1'b1;
        return MSG_HEATING;
    endfunction

    function automatic t_msg try_start(logic [9:0] door, logic [9:0] weight);
        int total;
        mode_q = MODE_READY;
        if (door != cfg.door_closed_level) return MSG_DOOR_OPEN;
        if (weight == '0) return MSG_EMPTY;
        if (weight > cfg.weight_limit) return MSG_OVERWEIGHT;
        if (entered_q == '0) begin
            total = int'(secs_q) + int'(cfg.quick_add_seconds);
        end else begin
            total = int'(digit_q[0]) * 600 + int'(digit_q[1]) * 60 +
                    int'(digit_q[2]) * 10 + int'(digit_q[3]);
        end
        if (total > int'(SECONDS_MAX)) total = int'(SECONDS_MAX);
        secs_q = 14'(total);
        if (entered_q == '0) show_secs();
        return start_heating();
    endfunction

    function automatic t_result apply_event(t_item ev);
        t_result r;
        t_msg    msg;
        logic    beep;
        msg = MSG_NONE;
        beep = 1'b0;
        if (ev.cmd == CMD_TICK) begin
            if (timer_q) begin
                if (secs_q != '0) begin
                    secs_q--;
                    show_secs();
                end else begin
                    clear_to_idle();
                    msg = MSG_DONE;
                end
            end
        end else if (ev.key_code <= KEY_DIGIT_LAST) begin
            beep = 1'b1;
            if (entered_q < 3'd4) begin
                digit_q[entered_q[1:0]] = {1'b0, ev.key_code};
                entered_q++;
                if (entered_q == 3'd4) msg = try_start(ev.door_level, ev.weight_level);
            end
        end else if (ev.key_code == KEY_START) begin
            beep = 1'b1;
            if (mode_q == MODE_SUSP) msg = start_heating();
            else msg = try_start(ev.door_level, ev.weight_level);
        end else if (ev.key_code == KEY_STOP) begin
            beep = 1'b1;
            if (mode_q == MODE_SUSP) begin
                clear_to_idle();
                msg = MSG_CLEARED;
            end else begin
                mode_q = MODE_SUSP;
                timer_q = 1'b0;
                heater_q = 1'b0;
                msg = MSG_PAUSE;
            end
        end
        r.mode = mode_q;
        r.heater_on = heater_q;
        r.timer_running = timer_q;
        r.secs = secs_q;
        r.digits.m_tens = digit_q[0];
        r.digits.m_ones = digit_q[1][3:0];
        r.digits.s_tens = digit_q[2][3:0];
        r.digits.s_ones = digit_q[3][3:0];
        r.message = msg;
        r.beep = beep;
        return r;
    endfunction

    function automatic void check_field(string name, int want, int got);
        if (want != got) begin
            $display("%0t %s mismatch: expected %0d actual %0d", $time, name, want, got);
            fails++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            cfg.door_closed_level = DOOR_CLOSED_RST;
            cfg.weight_limit = WEIGHT_LIM_RST;
            cfg.quick_add_seconds = QUICK_ADD_RST;
            clear_to_idle();
            status_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_DOOR_CLOSED: cfg.door_closed_level = i_cfg_data;
                    CFG_WEIGHT_LIM:  cfg.weight_limit = i_cfg_data;
                    CFG_QUICK_ADD:   cfg.quick_add_seconds = i_cfg_data[7:0];
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (status_q.size() == 0) begin
                    $display("%0t unexpected word: expected none actual mode %0d secs %0d",
                             $time, i_mode, i_seconds_left);
                    fails++;
                end else begin
                    want = status_q.pop_front();
                    check_field("mode", int'(want.mode), int'(i_mode));
                    check_field("heater_on", int'(want.heater_on), int'(i_heater_on));
                    check_field("timer_running", int'(want.timer_running),
                                int'(i_timer_running));
                    check_field("seconds_left", int'(want.secs), int'(i_seconds_left));
                    check_field("minute_tens", int'(want.digits.m_tens), int'(i_minute_tens));
                    check_field("minute_ones", int'(want.digits.m_ones), int'(i_minute_ones));
                    check_field("second_tens", int'(want.digits.s_tens), int'(i_second_tens));
                    check_field("second_ones", int'(want.digits.s_ones), int'(i_second_ones));
                    check_field("message", int'(want.message), int'(i_message));
                    check_field("beep", int'(want.beep), int'(i_beep));
                end
            end
            if (i_in_valid && !i_in_stall) begin
                status_q.push_back(apply_event(t_item'{i_cmd, i_key_code, i_door_level,
                                                       i_weight_level}));
            end
        end
        o_pending = status_q.size();
    end

endmodule

[sim/tb_top.sv]
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import oct_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int LONG_HOLD   = 300;
    localparam int SETTLE_WAIT = 8;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;

    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        cmd = 1'b0;
    logic [3:0]  key_code = '0;
    logic [9:0]  door_level = '0;
    logic [9:0]  weight_level = '0;

    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  mode;
    logic        heater_on;
    logic        timer_running;
    logic [13:0] seconds_left;
    logic [4:0]  minute_tens;
    logic [3:0]  minute_ones;
    logic [3:0]  second_tens;
    logic [3:0]  second_ones;
    logic [2:0]  message;
    logic        beep;

    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [9:0]  cfg_data = '0;

    int          fail_count;
    int          pending;
    int          cycles = 0;
    int          hold_asks = 0;

    int          sent = 0;
    int          burst_left = 0;
    int          no_idle_left = 0;
    logic        known_idle = 1'b0;
    logic [9:0]  cur_door = DOOR_CLOSED_RST;
    logic [9:0]  cur_weight = WEIGHT_LIM_RST;
    logic [7:0]  cur_quick = QUICK_ADD_RST;

    always #2 clk = ~clk;

    oven_cook_timer_controller dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .o_in_stall      (in_stall),
        .i_cmd           (cmd),
        .i_key_code      (key_code),
        .i_door_level    (door_level),
        .i_weight_level  (weight_level),
        .o_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .o_mode          (mode),
        .o_heater_on     (heater_on),
        .o_timer_running (timer_running),
        .o_seconds_left  (seconds_left),
        .o_minute_tens   (minute_tens),
        .o_minute_ones   (minute_ones),
        .o_second_tens   (second_tens),
        .o_second_ones   (second_ones),
        .o_message       (message),
        .o_beep          (beep),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    oct_checker u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .i_in_stall      (in_stall),
        .i_cmd           (cmd),
        .i_key_code      (key_code),
        .i_door_level    (door_level),
        .i_weight_level  (weight_level),
        .i_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .i_mode          (mode),
        .i_heater_on     (heater_on),
        .i_timer_running (timer_running),
        .i_seconds_left  (seconds_left),
        .i_minute_tens   (minute_tens),
        .i_minute_ones   (minute_ones),
        .i_second_tens   (second_tens),
        .i_second_ones   (second_ones),
        .i_message       (message),
        .i_beep          (beep),
        .i_cfg_valid     (cfg_valid),
        .i_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // receiver stall pattern, with a long hold-off when asked
    initial begin : receiver
        int style;
        int span;
        int holds_done;
        int n;
        style = 0;
        span = 0;
        holds_done = 0;
        n = 0;
        forever begin
            @(posedge clk);
            if (hold_asks > holds_done) begin
                holds_done++;
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                span = 0;
            end
            if (span == 0) begin
                style = $urandom_range(0, 3);
                span = $urandom_range(8, 80);
            end
            span--;
            n++;
            case (style)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 9) < 3);
                2: out_stall <= ($urandom_range(0, 9) < 8);
                default: out_stall <= ((n % 5) < 2);
            endcase
        end
    end

    task automatic send_word(input t_item it);
        int gap;
        if (burst_left == 0) begin
            gap = (no_idle_left > 0 || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 30);
        end
        burst_left--;
        if (no_idle_left > 0) no_idle_left--;
        if (!(it.cmd == CMD_KEY && it.key_code > KEY_START)) sent++;
        in_valid <= 1'b1;
        cmd <= it.cmd;
        key_code <= it.key_code;
        door_level <= it.door_level;
        weight_level <= it.weight_level;
        do @(posedge clk); while (in_stall);
    endtask

    function automatic logic [9:0] fit_weight();
        return (cur_weight == '0) ? 10'd0 : 10'($urandom_range(1, int'(cur_weight)));
    endfunction

    function automatic logic [9:0] bad_door();
        return cur_door ^ 10'($urandom_range(1, 1023));
    endfunction

    task automatic press(input logic [3:0] k, input logic [9:0] door, input logic [9:0] weight);
        t_item it;
        it.cmd = CMD_KEY;
        it.key_code = k;
        it.door_level = door;
        it.weight_level = weight;
        send_word(it);
    endtask

    task automatic press_ok(input logic [3:0] k);
        press(k, cur_door, fit_weight());
    endtask

    task automatic tick();
        t_item it;
        it.cmd = CMD_TICK;
        it.key_code = 4'($urandom);
        it.door_level = 10'($urandom);
        it.weight_level = 10'($urandom);
        send_word(it);
    endtask

    task automatic stop_twice();
        press(KEY_STOP, 10'($urandom), 10'($urandom));
        press(KEY_STOP, 10'($urandom), 10'($urandom));
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_WAIT) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [9:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic load_settings(input logic [9:0] door, input logic [9:0] weight,
                                 input logic [7:0] quick);
        settle();
        write_reg(CFG_DOOR_CLOSED, door);
        write_reg(CFG_WEIGHT_LIM, weight);
        write_reg(CFG_QUICK_ADD, {2'b00, quick});
        cfg_valid <= 1'b0;
        cur_door = door;
        cur_weight = weight;
        cur_quick = quick;
    endtask

    task automatic run_sequence();
        int kind;
        int n;
        int i;
        logic [3:0] d [4];
        t_item it;
        kind = $urandom_range(0, 99);
        if (kind < 25) begin
            repeat ($urandom_range(1, 8)) begin
                it.cmd = 1'($urandom);
                it.key_code = 4'($urandom);
                it.door_level = $urandom_range(0, 1) ? cur_door : 10'($urandom);
                it.weight_level = $urandom_range(0, 1) ? fit_weight() : 10'($urandom);
                send_word(it);
            end
            known_idle = 1'b0;
            return;
        end
        // start, stop, stop ends in idle from any mode
        if (!known_idle) begin
            press(KEY_START, bad_door(), 10'($urandom));
            stop_twice();
        end
        if (kind < 55) begin
            // four digits try to start the cook; ticks count down, to done if short, with pauses
            d[0] = '0;
            d[1] = '0;
            d[2] = 4'($urandom_range(0, 3));
            d[3] = 4'($urandom_range(0, 9));
            if ($urandom_range(0, 7) == 0) begin
                d[0] = 4'($urandom_range(0, 9));
                d[1] = 4'($urandom_range(0, 9));
            end
            for (i = 0; i < 3; i++) press(d[i], 10'($urandom), 10'($urandom));
            if ($urandom_range(0, 5) == 0) press(d[3], bad_door(), fit_weight());
            else press_ok(d[3]);
            if (d[0] != '0 || d[1] != '0) n = $urandom_range(2, 15);
            else n = int'(d[2]) * 10 + int'(d[3]) + 1 + $urandom_range(0, 2);
            repeat (n) begin
                if ($urandom_range(0, 19) == 0) begin
                    press(KEY_STOP, 10'($urandom), 10'($urandom));
                    repeat ($urandom_range(0, 3)) tick();
                    press(KEY_START, 10'($urandom), 10'($urandom));
                end
                tick();
            end
        end else if (kind < 70) begin
            // quick add, more starts while it runs
            repeat ($urandom_range(1, 3)) begin
                press_ok(KEY_START);
                repeat ($urandom_range(0, 6)) tick();
            end
        end else if (kind < 75) begin
            // repeated quick adds, reaching the ceiling only for large quick-add settings
            n = (cur_quick >= 8'd200) ? 42 : 3;
            repeat (n) press_ok(KEY_START);
            repeat (3) tick();
        end else if (kind < 85) begin
            press(KEY_START, bad_door(), fit_weight());
            press(KEY_START, cur_door, 10'd0);
            if (cur_weight != 10'h3FF) begin
                press(KEY_START, cur_door, 10'($urandom_range(int'(cur_weight) + 1, 1023)));
            end
            press_ok(KEY_START);
            tick();
        end else if (kind < 95) begin
            // partial digits over whatever time is shown
            if ($urandom_range(0, 1) == 1) begin
                press_ok(KEY_START);
                tick();
            end
            repeat ($urandom_range(1, 3)) begin
                press(4'($urandom_range(0, 9)), 10'($urandom), 10'($urandom));
            end
            press_ok(KEY_START);
            repeat ($urandom_range(1, 5)) tick();
        end else begin
            repeat (4) press_ok(4'($urandom_range(0, 9)));
            repeat ($urandom_range(1, 3)) begin
                press(4'($urandom_range(0, 9)), 10'($urandom), 10'($urandom));
            end
            tick();
        end
        stop_twice();
        known_idle = 1'b1;
    endtask

    task automatic run_phase(input logic [9:0] door, input logic [9:0] weight,
                             input logic [7:0] quick, input int quota, input logic long_hold);
        int stop_at;
        load_settings(door, weight, quick);
        known_idle = 1'b0;
        if (long_hold) begin
            hold_asks <= hold_asks + 1;
            no_idle_left = 200;
        end
        stop_at = sent + quota;
        while (sent < stop_at) run_sequence();
    endtask

    initial begin : stimulus
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        load_settings(DOOR_CLOSED_RST, WEIGHT_LIM_RST, QUICK_ADD_RST);

        tick();
        press(KEY_START + 4'd1, 10'h3FF, 10'h3FF);
        press(4'hF, 10'd0, 10'd0);
        press(KEY_START, 10'd0, 10'd100);
        press(KEY_START, 10'd1023, 10'd0);
        press(KEY_START, 10'd1023, 10'd501);
        press(KEY_START, 10'd1023, 10'd500);
        tick();
        press(KEY_STOP, 10'd1023, 10'd500);
        tick();
        press(KEY_START, 10'd0, 10'd0);
        stop_twice();
        stop_twice();
        repeat (3) press(4'd9, 10'($urandom), 10'($urandom));
        press(4'd9, 10'd1023, 10'd1);
        press(4'd5, 10'd1023, 10'd1);
        stop_twice();
        repeat (3) press(4'd0, 10'($urandom), 10'($urandom));
        press(4'd1, 10'd1023, 10'd250);
        repeat (3) tick();

        run_phase(DOOR_CLOSED_RST, WEIGHT_LIM_RST, QUICK_ADD_RST, 200, 1'b1);
        run_phase(10'd0, 10'd1023, 8'd255, 170, 1'b0);
        run_phase(10'($urandom), 10'd0, 8'd1, 140, 1'b0);
        run_phase(10'($urandom), 10'($urandom), 8'($urandom_range(1, 255)), 170, 1'b0);
        run_phase(10'd1023, 10'd1, 8'd255, 170, 1'b0);

        settle();
        if (fail_count == 0 && pending == 0) $display("TB_OK");
        else $display("TB_ERROR");
        $finish;
    end

endmodule
